// ===== rtl/block_bit_unpacker_with_reference_unit_defines.svh =====
// assertion macros for the unpacker rtl
// depends on nothing; taken in by the top level, the only file that checks its own logic
`ifndef BLOCK_BIT_UNPACKER_WITH_REFERENCE_UNIT_DEFINES_SVH
`define BLOCK_BIT_UNPACKER_WITH_REFERENCE_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BBU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BBU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bbu_pkg.sv =====
// shared types, constants and functions of the bit unpacker
// depends on nothing; used by the top level, the lanes and the merge stage
package bbu_pkg;

   localparam int BLOCK_SAMPLES = 64;
   localparam int LANES         = 8;
   localparam int GROUPS        = BLOCK_SAMPLES / LANES;
   localparam int GRP_W         = $clog2(GROUPS);
   localparam int WORDS_MAX     = 16;
   localparam int WIDX_W        = $clog2(WORDS_MAX);
   localparam int CNT_W         = $clog2(WORDS_MAX + 1);

   // request commands
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_DATA   = 1'b1;

   // width codes with a layout of their own; anything above is raw 16-bit
   localparam logic [4:0] CODE_W0  = 5'd0;
   localparam logic [4:0] CODE_W1  = 5'd1;
   localparam logic [4:0] CODE_W2  = 5'd2;
   localparam logic [4:0] CODE_W3  = 5'd3;
   localparam logic [4:0] CODE_W4  = 5'd4;
   localparam logic [4:0] CODE_W5  = 5'd5;
   localparam logic [4:0] CODE_W6  = 5'd6;
   localparam logic [4:0] CODE_W7  = 5'd7;
   localparam logic [4:0] CODE_W8  = 5'd8;
   localparam logic [4:0] CODE_W9  = 5'd9;
   localparam logic [4:0] CODE_W10 = 5'd10;

   // one lane's bytes of every stored word
   typedef logic [WORDS_MAX-1:0][7:0] byte_arr_type;
   typedef logic [LANES-1:0][15:0]    sample_arr_type;

   typedef struct packed {
      logic        cmd;
      logic [4:0]  width_code;
      logic [15:0] reference;
      logic [7:0]  lane0_byte;
      logic [7:0]  lane1_byte;
      logic [7:0]  lane2_byte;
      logic [7:0]  lane3_byte;
      logic [7:0]  lane4_byte;
      logic [7:0]  lane5_byte;
      logic [7:0]  lane6_byte;
      logic [7:0]  lane7_byte;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]      sample0;
      logic [15:0]      sample1;
      logic [15:0]      sample2;
      logic [15:0]      sample3;
      logic [15:0]      sample4;
      logic [15:0]      sample5;
      logic [15:0]      sample6;
      logic [15:0]      sample7;
      logic [GRP_W-1:0] group_index;
      logic             last_of_block;
   } rsp_payload_type;

   // control from the sequencer to the merge stage
   typedef struct packed {
      logic             load;
      logic [GRP_W-1:0] group;
      logic             last;
   } grp_ctrl_type;

   // packed words per block for a width code
   function automatic logic [CNT_W-1:0] words_for_code(input logic [4:0] code);
      logic [CNT_W-1:0] n;
      unique case (code) inside
         CODE_W0:           n = CNT_W'(0);
         CODE_W1:           n = CNT_W'(1);
         CODE_W2:           n = CNT_W'(2);
         CODE_W3:           n = CNT_W'(3);
         CODE_W4:           n = CNT_W'(4);
         CODE_W5:           n = CNT_W'(5);
         CODE_W6:           n = CNT_W'(6);
         CODE_W7, CODE_W8:  n = CNT_W'(8);
         CODE_W9, CODE_W10: n = CNT_W'(10);
         default:           n = CNT_W'(WORDS_MAX);
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/bbu_chan_if.sv =====
// valid/ready channel carrying one payload struct
// depends on nothing; payload type given where the channel is instantiated
interface bbu_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/block_bit_unpacker_with_reference_unit.sv =====
// top level of the frame-of-reference bit unpacker
// depends on bbu_pkg, bbu_chan_if, bbu_lane, bbu_merge and the defines header
//
//   channel    dir  payload                                   handshake
//   req_chan   in   cmd, width_code, reference, lane0..7_byte  valid/ready
//   rsp_chan   out  sample0..7, group_index, last_of_block     valid/ready
//
// a header or a data word is taken on each req_chan handshake; the last word of a block
// (or a header of width zero) starts the emit of eight groups, one group per cycle
// while rsp_chan.ready stays high, through the eight lanes and the merge register,
// with req_chan.ready low. a stalled response holds the emit sequencer on its group.
// reset is synchronous and clears control only; the word store is not
// cleared, every block writes all its words before they are read.
`include "block_bit_unpacker_with_reference_unit_defines.svh"

module block_bit_unpacker_with_reference_unit
   import bbu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bbu_chan_if.sink   req_chan,
   bbu_chan_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_COLLECT = 2'b01,
      ST_EMIT    = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [4:0]             width_ff, width_in;
   logic [15:0]            base_ff, base_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   open_ff, open_in;
   logic [GRP_W-1:0]       grp_ff, grp_in;
   logic [LANES-1:0][WORDS_MAX-1:0][7:0] store_ff;

   req_payload_type        req;
   logic [LANES-1:0][7:0]  req_bytes;
   logic                   req_fire;
   logic                   store_we;
   logic [CNT_W:0]         count_inc;
   logic                   can_load;
   grp_ctrl_type           grp;
   sample_arr_type         samples;

   assign req       = req_chan.data;
   assign req_bytes = {req.lane7_byte, req.lane6_byte, req.lane5_byte, req.lane4_byte,
                       req.lane3_byte, req.lane2_byte, req.lane1_byte, req.lane0_byte};

   assign req_chan.ready = (state_ff == ST_COLLECT);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign count_inc      = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign store_we       = req_fire && (req.cmd == CMD_DATA) && open_ff;

   // emit one group whenever the merge register can take it
   assign grp.load  = (state_ff == ST_EMIT) && can_load;
   assign grp.group = grp_ff;
   assign grp.last  = (grp_ff == GRP_W'(GROUPS - 1));

   // block sequencer
   always_comb begin
      state_in = state_ff;
      width_in = width_ff;
      base_in  = base_ff;
      count_in = count_ff;
      open_in  = open_ff;
      grp_in   = grp_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_fire && (req.cmd == CMD_HEADER)) begin
               // a new header drops any block still open
               width_in = req.width_code;
               base_in  = req.reference;
               count_in = '0;
               grp_in   = '0;
               if (words_for_code(req.width_code) == '0) begin
                  open_in  = 1'b0;
                  state_in = ST_EMIT;
               end else begin
                  open_in = 1'b1;
               end
            end else if (store_we) begin
               if (count_inc >= {1'b0, words_for_code(width_ff)}) begin
                  count_in = '0;
                  open_in  = 1'b0;
                  grp_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  count_in = count_inc[CNT_W-1:0];
               end
            end
         end
         ST_EMIT: begin
            if (grp.load) begin
               grp_in = grp_ff + GRP_W'(1);
               if (grp.last) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         width_ff <= '0;
         base_ff  <= '0;
         count_ff <= '0;
         open_ff  <= 1'b0;
         grp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         base_ff  <= base_in;
         count_ff <= count_in;
         open_ff  <= open_in;
         grp_ff   <= grp_in;
      end
   end

   // word store, one byte column per lane
   always_ff @(posedge clock) begin
      if (store_we) begin
         for (int j = 0; j < LANES; j++) begin
            store_ff[j][count_ff[WIDX_W-1:0]] <= req_bytes[j];
         end
      end
   end

   // eight lanes, raw mode pairs each lane with two byte columns
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      bbu_lane u_lane (
         .code      (width_ff),
         .group     (grp_ff),
         .base      (base_ff),
         .own_bytes (store_ff[l]),
         .raw_lo    (store_ff[2 * (l % 4)]),
         .raw_hi    (store_ff[2 * (l % 4) + 1]),
         .half      (1'(l / 4)),
         .sample    (samples[l])
      );
   end

   bbu_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .grp      (grp),
      .samples  (samples),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

   // checks on the sequencer
   `BBU_ASSERT_NEXT(a_last_group_ends_emit, clock, reset,
      grp.load && grp.last, state_ff == ST_COLLECT, "emit did not end after last group")
   `BBU_ASSERT_NEXT(a_zero_header_emits, clock, reset,
      req_fire && (req.cmd == CMD_HEADER) && (req.width_code == CODE_W0),
      (state_ff == ST_EMIT) && (grp_ff == '0) && !open_ff,
      "zero-width header did not start emitting")
   `BBU_ASSERT_NEXT(a_stray_data_ignored, clock, reset,
      req_fire && (req.cmd == CMD_DATA) && !open_ff,
      (state_ff == ST_COLLECT) && $stable(count_ff), "data outside a block was used")
   `BBU_ASSERT_SAME(a_count_bounded, clock, reset,
      1'b1, count_ff < CNT_W'(WORDS_MAX), "word count out of range")
   `BBU_ASSERT_SAME(a_emit_no_open_block, clock, reset,
      state_ff == ST_EMIT, !open_ff && (count_ff == '0), "block left open during emit")

endmodule

// ===== rtl/bbu_lane.sv =====
// one unpacking lane: extracts a lane's sample of the current group
// depends on bbu_pkg
module bbu_lane
   import bbu_pkg::*;
(
   input  logic [4:0]       code,
   input  logic [GRP_W-1:0] group,
   input  logic [15:0]      base,
   input  byte_arr_type     own_bytes,
   input  byte_arr_type     raw_lo,
   input  byte_arr_type     raw_hi,
   input  logic             half,
   output logic [15:0]      sample
);

   // bit layouts of every width code for one lane and one group
   function automatic logic [15:0] unpack(
      input logic [4:0]       c,
      input logic [GRP_W-1:0] g,
      input byte_arr_type     b,
      input byte_arr_type     lo,
      input byte_arr_type     hi,
      input logic             h
   );
      logic [WIDX_W-1:0] k;
      logic [7:0]        sh;
      logic [15:0]       v;
      k  = {g, h};
      sh = '0;
      v  = '0;
      unique case (c) inside
         CODE_W0: v = '0;
         CODE_W1: begin
            sh = b[0] >> g;
            v  = {15'd0, sh[0]};
         end
         CODE_W2: begin
            sh = b[{3'd0, g[2]}] >> {g[1:0], 1'b0};
            v  = {14'd0, sh[1:0]};
         end
         CODE_W3: begin
            case (g)
               3'd0:    v = {13'd0, b[0][2:0]};
               3'd1:    v = {13'd0, b[0][5:3]};
               3'd2:    v = {13'd0, b[2][6], b[0][7:6]};
               3'd3:    v = {13'd0, b[1][2:0]};
               3'd4:    v = {13'd0, b[1][5:3]};
               3'd5:    v = {13'd0, b[2][7], b[1][7:6]};
               3'd6:    v = {13'd0, b[2][2:0]};
               default: v = {13'd0, b[2][5:3]};
            endcase
         end
         CODE_W4: begin
            sh = b[{2'd0, g[2:1]}] >> {g[0], 2'b00};
            v  = {12'd0, sh[3:0]};
         end
         CODE_W5: begin
            case (g)
               3'd5:    v = {11'd0, b[3][6:5], b[0][7:5]};
               3'd6:    v = {11'd0, b[4][6:5], b[1][7:5]};
               3'd7:    v = {11'd0, b[4][7], b[3][7], b[2][7:5]};
               default: v = {11'd0, b[{1'b0, g}][4:0]};
            endcase
         end
         CODE_W6: begin
            case (g)
               3'd6:    v = {10'd0, b[2][7:6], b[1][7:6], b[0][7:6]};
               3'd7:    v = {10'd0, b[5][7:6], b[4][7:6], b[3][7:6]};
               default: v = {10'd0, b[{1'b0, g}][5:0]};
            endcase
         end
         CODE_W7, CODE_W8: v = {8'd0, b[{1'b0, g}]};
         CODE_W9, CODE_W10: begin
            // low groups take their top bits from word four, high groups from word nine
            if (!g[2]) begin
               sh = b[4] >> {g[1:0], 1'b0};
               v  = {6'd0, sh[1:0], b[{2'd0, g[1:0]}]};
            end else begin
               sh = b[9] >> {g[1:0], 1'b0};
               v  = {6'd0, sh[1:0], b[{1'b0, g} + 4'd1]};
            end
         end
         // raw little-endian pairs taken from the two partner lanes
         default: v = {hi[k], lo[k]};
      endcase
      return v;
   endfunction

   // reference added, wrapping at sixteen bits
   assign sample = unpack(code, group, own_bytes, raw_lo, raw_hi, half) + base;

endmodule

// ===== rtl/bbu_merge.sv =====
// merge stage: gathers the lane samples into one registered response
// depends on bbu_pkg and bbu_chan_if
module bbu_merge
   import bbu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  grp_ctrl_type    grp,
   input  sample_arr_type  samples,
   output logic            can_load,
   bbu_chan_if.source      rsp_chan
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   // the register is free when empty or being drained this cycle
   assign can_load = !valid_ff || rsp_chan.ready;

   // next response contents
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (grp.load) begin
         valid_in              = 1'b1;
         data_in.sample0       = samples[0];
         data_in.sample1       = samples[1];
         data_in.sample2       = samples[2];
         data_in.sample3       = samples[3];
         data_in.sample4       = samples[4];
         data_in.sample5       = samples[5];
         data_in.sample6       = samples[6];
         data_in.sample7       = samples[7];
         data_in.group_index   = grp.group;
         data_in.last_of_block = grp.last;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.data  = data_ff;

endmodule
